@@ src/cdc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the calendar date counter: request and config codes, the item
// record passed from the front stage to the date core, and calendar helpers.
package cdc_pkg;

	typedef enum logic [2:0] {
		REQ_LOAD      = 3'd0,
		REQ_SET_DAY   = 3'd1,
		REQ_SET_MONTH = 3'd2,
		REQ_SET_YEAR  = 3'd3,
		REQ_NEXT_DAY  = 3'd4,
		REQ_PREV_DAY  = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		CFG_DEF_DAY   = 2'd0,
		CFG_DEF_MONTH = 2'd1,
		CFG_DEF_YEAR  = 2'd2
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_YEAR_W = 16;

	localparam logic [4:0]  DAY_FIRST    = 5'd1;
	localparam logic [4:0]  DAY_DEC_LAST = 5'd31;
	localparam logic [4:0]  DAY_NONE     = 5'd0;
	localparam logic [3:0]  MONTH_JAN    = 4'd1;
	localparam logic [3:0]  MONTH_DEC    = 4'd12;
	localparam logic [3:0]  MONTH_NONE   = 4'd0;
	localparam logic [4:0]  R25_FIRST    = 5'd0;
	localparam logic [4:0]  R25_LAST     = 5'd24;

	localparam logic [4:0]  RST_DAY   = 5'd1;
	localparam logic [3:0]  RST_MONTH = 4'd1;
	localparam logic [15:0] RST_YEAR  = 16'd2000;
	localparam logic [4:0]  RST_R25   = 5'd0;   // 2000 mod 25

	typedef struct packed {
		req_t       req;
		logic [4:0] day;
		logic [3:0] month;
		logic       yr_over;
		logic [4:0] yr_r25;
	} item_t;

	// leap: divisible by 4 and not by 100, or by 400 (= by 16 and by 25)
	function automatic logic is_leap(input logic [3:0] lo, input logic [4:0] r25);
		return (lo[1:0] == 2'b00) && ((r25 != R25_FIRST) || (lo == 4'b0000));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			default: len = DAY_NONE;
		endcase
		return len;
	endfunction

endpackage

@@ src/cdc_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for the calendar date counter: request, result and
// config write. Uses cdc_pkg for the config field widths.
interface cdc_req_if #(parameter int YEAR_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [2:0]           req_type;
	logic [4:0]           new_day;
	logic [3:0]           new_month;
	logic [YEAR_BITS-1:0] new_year;

	modport source (output valid, req_type, new_day, new_month, new_year, input ready);
	modport sink   (input valid, req_type, new_day, new_month, new_year, output ready);
endinterface

interface cdc_res_if #(parameter int YEAR_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [4:0]           cur_day;
	logic [3:0]           cur_month;
	logic [YEAR_BITS-1:0] cur_year;
	logic                 bad_date;

	modport source (output valid, cur_day, cur_month, cur_year, bad_date, input ready);
	modport sink   (input valid, cur_day, cur_month, cur_year, bad_date, output ready);
endinterface

interface cdc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [cdc_pkg::CFG_IDX_W-1:0]  index;
	logic [cdc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ src/cdc_mod25.sv @@
`timescale 1ns / 1ps
// Year mod 25 by reciprocal multiply: q = (y * ceil(2^(N+5)/25)) >> (N+5).
// Uses cdc_pkg constants only through the caller.
module cdc_mod25 #(
	parameter int YEAR_BITS = 16
) (
	input  logic [YEAR_BITS-1:0] year,
	output logic [4:0]           r25
);
	localparam int SHIFT = YEAR_BITS + 5;
	localparam int PW    = 2 * YEAR_BITS + 1;
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'd24) / 64'd25;
	localparam logic [YEAR_BITS:0] RECIP_C = RECIP[YEAR_BITS:0];

	logic [PW-1:0]          prod;
	logic [YEAR_BITS-5:0]   quot;
	logic [YEAR_BITS-1:0]   quot_x;
	logic [YEAR_BITS-1:0]   q25;
	logic [YEAR_BITS-1:0]   rem;

	assign prod   = PW'(year) * PW'(RECIP_C);
	assign quot   = prod[PW-1:SHIFT];
	assign quot_x = YEAR_BITS'(quot);
	assign q25    = (quot_x << 4) + (quot_x << 3) + quot_x;
	assign rem    = year - q25;
	assign r25    = rem[4:0];
endmodule

@@ src/cdc_front.sv @@
`timescale 1ns / 1ps
// Front end: config registers, input register, default resolution for loads
// and year mod 25; feeds the date core. Depends on cdc_pkg, cdc_if, cdc_mod25.
module cdc_front #(
	parameter int YEAR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cdc_req_if.sink              req,
	cdc_cfg_if.sink              cfg,
	input  logic                 core_ready,
	output logic                 item_valid,
	output cdc_pkg::item_t       item,
	output logic [YEAR_BITS-1:0] item_year
);
	import cdc_pkg::*;

	logic [4:0]            dflt_day_q;
	logic [3:0]            dflt_month_q;
	logic [CFG_YEAR_W-1:0] dflt_year_q;

	logic                  v_s1;
	logic [2:0]            type_s1;
	logic [4:0]            day_s1;
	logic [3:0]            month_s1;
	logic [YEAR_BITS-1:0]  year_s1;

	logic                  v_s2;
	item_t                 item_s2;
	logic [YEAR_BITS-1:0]  year_s2;

	logic                  en1, en2;
	logic                  is_load;
	logic [YEAR_BITS-1:0]  dflt_year;
	logic                  dflt_over;
	logic [YEAR_BITS-1:0]  res_year;
	logic [4:0]            res_r25;
	item_t                 nxt_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_day_q   <= RST_DAY;
			dflt_month_q <= RST_MONTH;
			dflt_year_q  <= RST_YEAR;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_DEF_DAY:   dflt_day_q   <= cfg.data[4:0];
				CFG_DEF_MONTH: dflt_month_q <= cfg.data[3:0];
				CFG_DEF_YEAR:  dflt_year_q  <= cfg.data[CFG_YEAR_W-1:0];
				default: ;
			endcase
		end
	end

	assign dflt_year = YEAR_BITS'(dflt_year_q);
	generate
		if (YEAR_BITS >= CFG_YEAR_W) begin : g_wide
			assign dflt_over = 1'b0;
		end else begin : g_narrow
			assign dflt_over = |dflt_year_q[CFG_YEAR_W-1:YEAR_BITS];
		end
	endgenerate

	assign en2       = !v_s2 || core_ready;
	assign en1       = !v_s1 || en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req.valid) begin
			type_s1  <= req.req_type;
			day_s1   <= req.new_day;
			month_s1 <= req.new_month;
			year_s1  <= req.new_year;
		end
	end

	assign is_load  = (req_t'(type_s1) == REQ_LOAD);
	assign res_year = (is_load && year_s1 == '0) ? dflt_year : year_s1;

	cdc_mod25 #(.YEAR_BITS(YEAR_BITS)) u_mod25 (
		.year (res_year),
		.r25  (res_r25)
	);

	always_comb begin
		nxt_item.req     = req_t'(type_s1);
		nxt_item.day     = (is_load && day_s1 == DAY_NONE) ? dflt_day_q : day_s1;
		nxt_item.month   = (is_load && month_s1 == MONTH_NONE) ? dflt_month_q : month_s1;
		nxt_item.yr_over = is_load && (year_s1 == '0) && dflt_over;
		nxt_item.yr_r25  = res_r25;
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			item_s2 <= nxt_item;
			year_s2 <= res_year;
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;
	assign item_year  = year_s2;
endmodule

@@ src/cdc_core.sv @@
`timescale 1ns / 1ps
// Date core: stored date with its year mod 25, one request applied per cycle
// while the result register is free or being read, result register. Depends on cdc_pkg and cdc_if.
module cdc_core #(
	parameter int YEAR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  cdc_pkg::item_t       item,
	input  logic [YEAR_BITS-1:0] item_year,
	output logic                 core_ready,
	cdc_res_if.source            res
);
	import cdc_pkg::*;

	localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
	localparam logic [YEAR_BITS-1:0] YEAR_ONE = YEAR_BITS'(1);

	logic [4:0]           day_q;
	logic [3:0]           month_q;
	logic [YEAR_BITS-1:0] year_q;
	logic [4:0]           r25_q;

	logic                 out_v_q;
	logic [4:0]           out_day_q;
	logic [3:0]           out_month_q;
	logic [YEAR_BITS-1:0] out_year_q;
	logic                 out_bad_q;

	logic                 en3, take;
	logic                 leap_q, leap_op;
	logic [4:0]           len_q, len_op, len_prev;
	logic [4:0]           nxt_day;
	logic [3:0]           nxt_month;
	logic [YEAR_BITS-1:0] nxt_year;
	logic [4:0]           nxt_r25;
	logic                 nxt_bad;

	assign en3        = !out_v_q || res.ready;
	assign take       = en3 && item_valid;
	assign core_ready = en3;

	assign leap_q   = is_leap(year_q[3:0], r25_q);
	assign leap_op  = is_leap(item_year[3:0], item.yr_r25);
	assign len_q    = month_len(month_q, leap_q);
	assign len_prev = month_len(month_q - 4'd1, leap_q);

	always_comb begin
		nxt_day   = day_q;
		nxt_month = month_q;
		nxt_year  = year_q;
		nxt_r25   = r25_q;
		nxt_bad   = 1'b0;
		len_op    = DAY_NONE;
		case (item.req)
			REQ_LOAD: begin
				len_op = month_len(item.month, leap_op);
				if (len_op != DAY_NONE && item.day != DAY_NONE && item.day <= len_op &&
						!item.yr_over) begin
					nxt_day   = item.day;
					nxt_month = item.month;
					nxt_year  = item_year;
					nxt_r25   = item.yr_r25;
				end else begin
					nxt_bad = 1'b1;
				end
			end
			REQ_SET_DAY: begin
				if (len_q != DAY_NONE && item.day != DAY_NONE && item.day <= len_q)
					nxt_day = item.day;
				else
					nxt_bad = 1'b1;
			end
			REQ_SET_MONTH: begin
				len_op = month_len(item.month, leap_q);
				if (len_op != DAY_NONE && day_q != DAY_NONE && day_q <= len_op)
					nxt_month = item.month;
				else
					nxt_bad = 1'b1;
			end
			REQ_SET_YEAR: begin
				len_op = month_len(month_q, leap_op);
				if (len_op != DAY_NONE && day_q != DAY_NONE && day_q <= len_op) begin
					nxt_year = item_year;
					nxt_r25  = item.yr_r25;
				end else begin
					nxt_bad = 1'b1;
				end
			end
			REQ_NEXT_DAY: begin
				if (len_q == DAY_NONE) begin
					nxt_bad = 1'b1;
				end else if (day_q < len_q) begin
					nxt_day = day_q + 5'd1;
				end else if (month_q < MONTH_DEC) begin
					nxt_day   = DAY_FIRST;
					nxt_month = month_q + 4'd1;
				end else if (year_q != YEAR_MAX) begin
					nxt_day   = DAY_FIRST;
					nxt_month = MONTH_JAN;
					nxt_year  = year_q + YEAR_ONE;
					nxt_r25   = (r25_q == R25_LAST) ? R25_FIRST : r25_q + 5'd1;
				end else begin
					nxt_bad = 1'b1;
				end
			end
			REQ_PREV_DAY: begin
				if (len_q == DAY_NONE) begin
					nxt_bad = 1'b1;
				end else if (day_q > DAY_FIRST) begin
					nxt_day = day_q - 5'd1;
				end else if (month_q > MONTH_JAN) begin
					nxt_month = month_q - 4'd1;
					nxt_day   = len_prev;
				end else if (year_q != '0) begin
					nxt_day   = DAY_DEC_LAST;
					nxt_month = MONTH_DEC;
					nxt_year  = year_q - YEAR_ONE;
					nxt_r25   = (r25_q == R25_FIRST) ? R25_LAST : r25_q - 5'd1;
				end else begin
					nxt_bad = 1'b1;
				end
			end
			default: nxt_bad = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= RST_DAY;
			month_q <= RST_MONTH;
			year_q  <= YEAR_BITS'(RST_YEAR);
			r25_q   <= RST_R25;
			out_v_q <= 1'b0;
		end else begin
			if (en3) out_v_q <= item_valid;
			if (take) begin
				day_q   <= nxt_day;
				month_q <= nxt_month;
				year_q  <= nxt_year;
				r25_q   <= nxt_r25;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_day_q   <= nxt_day;
			out_month_q <= nxt_month;
			out_year_q  <= nxt_year;
			out_bad_q   <= nxt_bad;
		end
	end

	assign res.valid     = out_v_q;
	assign res.cur_day   = out_day_q;
	assign res.cur_month = out_month_q;
	assign res.cur_year  = out_year_q;
	assign res.bad_date  = out_bad_q;

	a_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(day_q != DAY_NONE) && (day_q <= month_len(month_q, leap_q)))
		else $error("stored date out of range");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(take && nxt_bad) |=> ($stable(day_q) && $stable(month_q) && $stable(year_q)))
		else $error("rejected request changed the date");

	a_r25_range: assert property (@(posedge clk) disable iff (!arst_n)
		r25_q <= R25_LAST)
		else $error("year residue out of range");

	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (out_day_q == day_q && out_month_q == month_q && out_year_q == year_q))
		else $error("result differs from stored date");
endmodule

@@ src/calendar_date_counter_top.sv @@
`timescale 1ns / 1ps
// Gregorian date counter (load, set day/month/year, next/previous day) with
// full leap-year rules. One request per cycle unless the result output stalls;
// a request passes through the input register, operand register and result
// register in that order, and the date registers are written when the core
// takes it. Rejected requests return the unchanged date with bad_date set.
// Config writes are taken every cycle and only change the defaults used by
// later loads.
// Depends on cdc_pkg, cdc_if, cdc_front and cdc_core.
module calendar_date_counter_top #(
	parameter int YEAR_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	cdc_req_if.sink       req,
	cdc_res_if.source     res,
	cdc_cfg_if.sink       cfg
);
	import cdc_pkg::*;

	logic                 core_ready;
	logic                 item_valid;
	item_t                item;
	logic [YEAR_BITS-1:0] item_year;

	cdc_front #(.YEAR_BITS(YEAR_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.core_ready (core_ready),
		.item_valid (item_valid),
		.item       (item),
		.item_year  (item_year)
	);

	cdc_core #(.YEAR_BITS(YEAR_BITS)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_year  (item_year),
		.core_ready (core_ready),
		.res        (res)
	);
endmodule

@@ sim/calendar_date_counter_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for calendar_date_counter_top: a queue-fed request driver, a result
// monitor against a built-in date predictor, and default-date writes between phases.
// Depends on cdc_pkg, cdc_if and the calendar_date_counter_top RTL.
module calendar_date_counter_top_test;
	import cdc_pkg::*;

	localparam int          YR_W     = 16;
	localparam int unsigned YEAR_TOP = 65535;
	localparam logic [2:0]  REQ_BAD_A = 3'd6;
	localparam logic [2:0]  REQ_BAD_B = 3'd7;
	localparam int          N_PHASES  = 6;
	localparam int          PHASE_LEN = 300;
	localparam int          HOLD_LEN  = 400;

	typedef struct packed {
		logic [2:0]      kind;
		logic [4:0]      day;
		logic [3:0]      month;
		logic [YR_W-1:0] year;
	} request_t;

	typedef struct packed {
		logic [4:0]      day;
		logic [3:0]      month;
		logic [YR_W-1:0] year;
		logic            bad;
	} date_t;

	logic clk;
	logic arst_n;

	cdc_req_if #(.YEAR_BITS(YR_W)) req_ch ();
	cdc_res_if #(.YEAR_BITS(YR_W)) res_ch ();
	cdc_cfg_if                     cfg_ch ();

	calendar_date_counter_top #(.YEAR_BITS(YR_W)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	request_t    queued_requests[$];
	date_t       due_dates[$];

	int unsigned day_now = 1;
	int unsigned month_now = 1;
	int unsigned year_now = 2000;
	int unsigned def_day, def_month, def_year;

	int unsigned notable_years[14] = '{0, 1, 3, 4, 100, 400, 1600, 1899, 1900, 2000, 2100,
		2400, 65534, 65535};

	int  mismatches = 0;
	int  accepted = 0;
	int  results_seen = 0;
	int  rejected = 0;
	int  stall_kick;
	int  stall_seen;
	int  stall_left;
	logic calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in(int unsigned m, int unsigned y);
		case (m)
			2: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default: return 0;
		endcase
	endfunction

	function automatic logic valid_date(int unsigned d, int unsigned m, int unsigned y);
		int unsigned len;
		len = days_in(m, y);
		return len != 0 && d >= 1 && d <= len && y <= YEAR_TOP;
	endfunction

	// Applies one request to the tracked date and returns what the block should report.
	function automatic date_t apply_date_request(request_t r);
		date_t       res;
		int unsigned d, m, y, len;
		logic        bad;
		bad = 1'b0;
		case (r.kind)
			REQ_LOAD: begin
				d = (r.day != 0) ? r.day : def_day;
				m = (r.month != 0) ? r.month : def_month;
				y = (r.year != 0) ? r.year : def_year;
				if (valid_date(d, m, y)) begin
					day_now = d;
					month_now = m;
					year_now = y;
				end else begin
					bad = 1'b1;
				end
			end
			REQ_SET_DAY: begin
				if (valid_date(r.day, month_now, year_now)) day_now = r.day;
				else bad = 1'b1;
			end
			REQ_SET_MONTH: begin
				if (valid_date(day_now, r.month, year_now)) month_now = r.month;
				else bad = 1'b1;
			end
			REQ_SET_YEAR: begin
				if (valid_date(day_now, month_now, r.year)) year_now = r.year;
				else bad = 1'b1;
			end
			REQ_NEXT_DAY: begin
				len = days_in(month_now, year_now);
				if (len == 0) begin
					bad = 1'b1;
				end else if (day_now < len) begin
					day_now++;
				end else if (month_now < 12) begin
					day_now = 1;
					month_now++;
				end else if (year_now < YEAR_TOP) begin
					day_now = 1;
					month_now = 1;
					year_now++;
				end else begin
					bad = 1'b1;
				end
			end
			REQ_PREV_DAY: begin
				if (days_in(month_now, year_now) == 0) begin
					bad = 1'b1;
				end else if (day_now > 1) begin
					day_now--;
				end else if (month_now > 1) begin
					month_now--;
					day_now = days_in(month_now, year_now);
				end else if (year_now > 0) begin
					month_now = 12;
					year_now--;
					day_now = 31;
				end else begin
					bad = 1'b1;
				end
			end
			default: bad = 1'b1;
		endcase
		res.day = day_now[4:0];
		res.month = month_now[3:0];
		res.year = year_now[YR_W-1:0];
		res.bad = bad;
		return res;
	endfunction

	function automatic request_t mk(logic [2:0] kind, int unsigned d, int unsigned m,
		int unsigned y);
		request_t r;
		r.kind = kind;
		r.day = d[4:0];
		r.month = m[3:0];
		r.year = y[YR_W-1:0];
		return r;
	endfunction

	function automatic int unsigned pick_year();
		if ($urandom_range(9) < 6) return notable_years[$urandom_range(13)];
		return $urandom_range(YEAR_TOP);
	endfunction

	function automatic request_t roll_request();
		request_t    r;
		int unsigned pick;
		pick = $urandom_range(99);
		r = mk(REQ_NEXT_DAY, $urandom_range(31), $urandom_range(15), $urandom_range(YEAR_TOP));
		if (pick < 16) begin
			r.kind = REQ_LOAD;
			case ($urandom_range(9))
				0: r.day = 5'd0;
				1, 2, 3, 4: r.day = 5'($urandom_range(31, 27));
				default: r.day = 5'($urandom_range(31, 1));
			endcase
			case ($urandom_range(9))
				0: r.month = 4'd0;
				1: r.month = 4'($urandom_range(15, 13));
				2, 3: r.month = 4'd2;
				4: r.month = 4'd12;
				default: r.month = 4'($urandom_range(12, 1));
			endcase
			r.year = YR_W'(pick_year());
		end else if (pick < 26) begin
			r.kind = REQ_SET_DAY;
		end else if (pick < 36) begin
			r.kind = REQ_SET_MONTH;
		end else if (pick < 46) begin
			r.kind = REQ_SET_YEAR;
			r.year = YR_W'(pick_year());
		end else if (pick < 72) begin
			r.kind = REQ_NEXT_DAY;
		end else if (pick < 97) begin
			r.kind = REQ_PREV_DAY;
		end else begin
			r.kind = $urandom_range(1) ? REQ_BAD_A : REQ_BAD_B;
		end
		return r;
	endfunction

	// Mostly single random requests, with occasional runs of day steps to cross boundaries.
	task automatic queue_random(int n);
		int       count;
		int       run;
		request_t step;
		count = 0;
		while (count < n) begin
			if ($urandom_range(19) == 0) begin
				run = $urandom_range(60, 20);
				repeat (run) begin
					step = roll_request();
					step.kind = $urandom_range(1) ? REQ_NEXT_DAY : REQ_PREV_DAY;
					queued_requests.push_back(step);
				end
				count += run;
			end else begin
				queued_requests.push_back(roll_request());
				count++;
			end
		end
	endtask

	task automatic wait_drained();
		while (queued_requests.size() != 0 || req_ch.valid || due_dates.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_default(cfg_idx_t idx, int unsigned value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_DEF_DAY:   def_day = value & 32'h1F;
			CFG_DEF_MONTH: def_month = value & 32'hF;
			CFG_DEF_YEAR:  def_year = value & 32'hFFFF;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (mismatches < 100)
			$display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, results_seen,
				field, got, want);
		mismatches++;
	endtask

	function automatic logic take_break();
		return !calm && $urandom_range(99) < 37;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= REQ_LOAD;
			req_ch.new_day <= '0;
			req_ch.new_month <= '0;
			req_ch.new_year <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				due_dates.push_back(apply_date_request(mk(req_ch.req_type, req_ch.new_day,
					req_ch.new_month, req_ch.new_year)));
				accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (queued_requests.size() != 0 && !take_break()) begin
					request_t r;
					r = queued_requests.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= r.kind;
					req_ch.new_day <= r.day;
					req_ch.new_month <= r.month;
					req_ch.new_year <= r.year;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long output hold-off, started by bumping stall_kick
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			stall_seen <= 0;
		end else if (stall_kick != stall_seen) begin
			stall_left <= HOLD_LEN;
			stall_seen <= stall_kick;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_dates.size() == 0) begin
					flag_mismatch("unexpected result", 1, 0);
				end else begin
					date_t want;
					want = due_dates.pop_front();
					if (res_ch.cur_day !== want.day)
						flag_mismatch("cur_day", res_ch.cur_day, want.day);
					if (res_ch.cur_month !== want.month)
						flag_mismatch("cur_month", res_ch.cur_month, want.month);
					if (res_ch.cur_year !== want.year)
						flag_mismatch("cur_year", res_ch.cur_year, want.year);
					if (res_ch.bad_date !== want.bad)
						flag_mismatch("bad_date", res_ch.bad_date, want.bad);
					if (want.bad) rejected++;
				end
				results_seen++;
			end
			res_ch.ready <= (stall_left == 0) && !take_break();
		end
	end

	initial begin
		int unsigned settings[N_PHASES][3];
		arst_n = 1'b0;
		calm = 1'b0;
		stall_kick = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_DEF_DAY;
		cfg_ch.data = '0;
		def_day = 1;
		def_month = 1;
		def_year = 2000;
		settings = '{'{31, 12, 65535}, '{29, 2, 1900}, '{1, 1, 0}, '{0, 15, 2024},
			'{$urandom_range(31), $urandom_range(15), $urandom_range(65535)},
			'{1, 1, 2000}};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset date, leap rules, year ends, rejects
		queued_requests.push_back(mk(REQ_NEXT_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_PREV_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_PREV_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_LOAD, 0, 0, 0));
		queued_requests.push_back(mk(REQ_LOAD, 29, 2, 2000));
		queued_requests.push_back(mk(REQ_SET_YEAR, 0, 0, 1900));
		queued_requests.push_back(mk(REQ_SET_YEAR, 0, 0, 0));
		queued_requests.push_back(mk(REQ_NEXT_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_LOAD, 29, 2, 1900));
		queued_requests.push_back(mk(REQ_LOAD, 28, 2, 2100));
		queued_requests.push_back(mk(REQ_NEXT_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_PREV_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_LOAD, 31, 12, 65535));
		queued_requests.push_back(mk(REQ_NEXT_DAY, 31, 15, 65535));
		queued_requests.push_back(mk(REQ_PREV_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_LOAD, 1, 1, 1));
		queued_requests.push_back(mk(REQ_SET_YEAR, 0, 0, 0));
		queued_requests.push_back(mk(REQ_PREV_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_SET_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_SET_DAY, 31, 0, 0));
		queued_requests.push_back(mk(REQ_SET_MONTH, 0, 4, 0));
		queued_requests.push_back(mk(REQ_SET_MONTH, 0, 0, 0));
		queued_requests.push_back(mk(REQ_SET_MONTH, 0, 15, 0));
		queued_requests.push_back(mk(REQ_SET_MONTH, 0, 12, 0));
		queued_requests.push_back(mk(REQ_NEXT_DAY, 0, 0, 0));
		queued_requests.push_back(mk(REQ_LOAD, 31, 15, 65535));
		queued_requests.push_back(mk(REQ_BAD_A, 31, 15, 65535));
		queued_requests.push_back(mk(REQ_BAD_B, 0, 0, 0));
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			for (int k = 0; k < 3; k++) begin
				case ((k + p) % 3)
					0: write_default(CFG_DEF_DAY, settings[p][0]);
					1: write_default(CFG_DEF_MONTH, settings[p][1]);
					default: write_default(CFG_DEF_YEAR, settings[p][2]);
				endcase
			end
			calm = (p == 3);
			if (p == 1) begin
				queue_random(PHASE_LEN);
				stall_kick++;
			end else if (p == 2) begin
				queue_random(PHASE_LEN / 2);
				wait_drained();
				queue_random(PHASE_LEN / 2);
			end else begin
				queue_random(PHASE_LEN);
			end
			wait_drained();
		end
		calm = 1'b0;

		repeat (8) @(posedge clk);
		$display("covered %0d requests (%0d rejected) over %0d default-date settings,", accepted,
			rejected, N_PHASES);
		$display("with a long output hold-off, a mid-phase drain and an idle-free phase");
		if (mismatches == 0 && due_dates.size() == 0 && results_seen == accepted)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
src/cdc_pkg.sv
src/cdc_if.sv
src/cdc_mod25.sv
src/cdc_front.sv
src/cdc_core.sv
src/calendar_date_counter_top.sv
sim/calendar_date_counter_top_test.sv
